>>> sv/temperature_advection_stencil_macros.svh
// Assertion helpers for the advection stencil.
// Every use expects clk and arst_n in the scope where it stands.
`ifndef TEMPERATURE_ADVECTION_STENCIL_MACROS_SVH
`define TEMPERATURE_ADVECTION_STENCIL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TAS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds after the delay dly, counted from the antecedent.
`define TAS_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

>>> sv/tas_pkg.sv
package tas_pkg;

	// Data format of all temperatures, velocities and gains
	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Configuration port geometry
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 4;
	localparam int REG_IDX_W  = 2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_ADVECT_GAIN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIFFUSE_GAIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WALL_HOT     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_WALL_COLD    = 2'd3;

	// Edge codes
	localparam logic [1:0] COL_LEFT   = 2'd1;
	localparam logic [1:0] COL_RIGHT  = 2'd2;
	localparam logic [1:0] ROW_BOTTOM = 2'd1;
	localparam logic [1:0] ROW_TOP    = 2'd2;

	// Saturation limits of the result
	localparam logic signed [DATA_W-1:0] LOAD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] LOAD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] centre_temp;
		logic signed [DATA_W-1:0] north_temp;
		logic signed [DATA_W-1:0] south_temp;
		logic signed [DATA_W-1:0] east_temp;
		logic signed [DATA_W-1:0] west_temp;
		logic signed [DATA_W-1:0] u_left;
		logic signed [DATA_W-1:0] u_right;
		logic signed [DATA_W-1:0] v_down;
		logic signed [DATA_W-1:0] v_up;
		logic        [1:0]        col_edge;
		logic        [1:0]        row_edge;
	} stencil_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] load_value;
		logic                     saturated;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] advect_gain;
		logic signed [DATA_W-1:0] diffuse_gain;
		logic signed [DATA_W-1:0] wall_hot;
		logic signed [DATA_W-1:0] wall_cold;
	} cfg_t;

endpackage

>>> sv/tas_regs.sv
module tas_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tas_pkg::PADDR_W-1:0]       paddr,
	input  logic [tas_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tas_pkg::APB_DATA_W-1:0]    prdata,
	output tas_pkg::cfg_t                     cfg
);

	tas_pkg::cfg_t                     cfg_q;
	logic [tas_pkg::REG_IDX_W-1:0]     idx;
	logic                              wr_en;

	assign idx   = paddr[tas_pkg::PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	// Write a register at the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				tas_pkg::REG_ADVECT_GAIN:  cfg_q.advect_gain  <= pwdata;
				tas_pkg::REG_DIFFUSE_GAIN: cfg_q.diffuse_gain <= pwdata;
				tas_pkg::REG_WALL_HOT:     cfg_q.wall_hot     <= pwdata;
				tas_pkg::REG_WALL_COLD:    cfg_q.wall_cold    <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			tas_pkg::REG_ADVECT_GAIN:  prdata = cfg_q.advect_gain;
			tas_pkg::REG_DIFFUSE_GAIN: prdata = cfg_q.diffuse_gain;
			tas_pkg::REG_WALL_HOT:     prdata = cfg_q.wall_hot;
			tas_pkg::REG_WALL_COLD:    prdata = cfg_q.wall_cold;
			default:                   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tas_stencil.sv
module tas_stencil #(
	parameter int FRAC_BITS = tas_pkg::FRAC_BITS_DEF,
	localparam int DW  = tas_pkg::DATA_W,
	localparam int SW  = DW + 1,
	localparam int PW  = 2 * SW,
	localparam int FXW = PW + 1,
	localparam int FW  = FXW - FRAC_BITS - 1,
	localparam int WPW = 2 * DW,
	localparam int WRW = WPW + 1 - FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_in,
	input  tas_pkg::stencil_t     stencil,
	input  tas_pkg::cfg_t         cfg,
	output logic                  valid_s3,
	output logic signed [FW-1:0]  flux_s3,
	output logic signed [WRW-1:0] wall_s3,
	output logic signed [DW-1:0]  centre_s3
);

	localparam logic signed [FXW-1:0]   FLUX_HALF = {{(FXW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [WPW:0]     WALL_HALF = {{WPW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic signed [DW-1:0]  w_sel, e_sel, n_sel, s_sel;
	logic signed [DW-1:0]  ul_sel, ur_sel, vd_sel, vu_sel, wall_sel;

	logic                  valid_s1, valid_s2;
	logic signed [SW-1:0]  su_s1, dx_s1, sv_s1, dy_s1;
	logic signed [DW-1:0]  wall_s1, centre_s1, centre_s2;
	logic signed [PW-1:0]  px_s2, py_s2;
	logic signed [WPW-1:0] pw_s2;
	logic signed [FXW-1:0] flux_sum;
	logic signed [WPW:0]   wall_sum;

	// Use wall or centre values and zero face velocities at the edges
	always_comb begin
		w_sel    = stencil.west_temp;
		ul_sel   = stencil.u_left;
		e_sel    = stencil.east_temp;
		ur_sel   = stencil.u_right;
		wall_sel = '0;
		if (stencil.col_edge == tas_pkg::COL_LEFT) begin
			w_sel    = cfg.wall_hot;
			ul_sel   = '0;
			wall_sel = cfg.wall_hot;
		end else if (stencil.col_edge == tas_pkg::COL_RIGHT) begin
			e_sel    = cfg.wall_cold;
			ur_sel   = '0;
			wall_sel = cfg.wall_cold;
		end
		s_sel  = stencil.south_temp;
		vd_sel = stencil.v_down;
		n_sel  = stencil.north_temp;
		vu_sel = stencil.v_up;
		if (stencil.row_edge == tas_pkg::ROW_BOTTOM) begin
			s_sel  = stencil.centre_temp;
			vd_sel = '0;
		end else if (stencil.row_edge == tas_pkg::ROW_TOP) begin
			n_sel  = stencil.centre_temp;
			vu_sel = '0;
		end
	end

	// Round the flux (extra bit takes the factor one half) and the wall term
	assign flux_sum = FXW'(px_s2) + FXW'(py_s2) + FLUX_HALF;
	assign wall_sum = (WPW + 1)'(pw_s2) + WALL_HALF;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Sums and differences, products, then rounding
	always_ff @(posedge clk) begin
		su_s1     <= SW'(ul_sel) + SW'(ur_sel);
		dx_s1     <= SW'(e_sel) - SW'(w_sel);
		sv_s1     <= SW'(vd_sel) + SW'(vu_sel);
		dy_s1     <= SW'(n_sel) - SW'(s_sel);
		wall_s1   <= wall_sel;
		centre_s1 <= stencil.centre_temp;

		px_s2     <= su_s1 * dx_s1;
		py_s2     <= sv_s1 * dy_s1;
		pw_s2     <= cfg.diffuse_gain * wall_s1;
		centre_s2 <= centre_s1;

		flux_s3   <= flux_sum[FXW-1:FRAC_BITS+1];
		wall_s3   <= wall_sum[WPW:FRAC_BITS];
		centre_s3 <= centre_s2;
	end

endmodule

>>> sv/tas_scale.sv
module tas_scale #(
	parameter int FRAC_BITS = tas_pkg::FRAC_BITS_DEF,
	localparam int DW  = tas_pkg::DATA_W,
	localparam int FW  = 2 * (DW + 1) - FRAC_BITS,
	localparam int WRW = 2 * DW + 1 - FRAC_BITS,
	localparam int LW  = FW / 2,
	localparam int HW  = FW - LW,
	localparam int GPW = DW + FW,
	localparam int ARW = GPW + 1 - FRAC_BITS,
	localparam int AW  = ARW + 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_in,
	input  logic signed [FW-1:0]    flux_in,
	input  logic signed [WRW-1:0]   wall_in,
	input  logic signed [DW-1:0]    centre_in,
	input  logic signed [DW-1:0]    advect_gain,
	output logic                    done,
	output tas_pkg::result_t        result
);

	localparam logic signed [GPW:0] GAIN_HALF = {{GPW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic                    valid_s4, valid_s5, valid_s6;
	logic signed [DW+LW:0]   pl_s4;
	logic signed [DW+HW-1:0] ph_s4;
	logic signed [WRW-1:0]   wall_s4, wall_s5;
	logic signed [DW-1:0]    centre_s4, centre_s5;
	logic signed [ARW-1:0]   ar_s5;
	logic signed [GPW:0]     prod;
	logic signed [AW-1:0]    acc;
	logic [AW-DW:0]          acc_top;
	logic                    fits;
	tas_pkg::result_t        res_s6;

	// Join the two partial products and round the gain term
	assign prod = (GPW + 1)'($signed({ph_s4, {LW{1'b0}}})) + (GPW + 1)'(pl_s4) + GAIN_HALF;

	// Final sum and clip to the data width
	assign acc     = AW'(centre_s5) - AW'(ar_s5) + AW'(wall_s5);
	assign acc_top = acc[AW-1:DW-1];
	assign fits    = (&acc_top) || !(|acc_top);

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_in;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Split gain multiply, rounding, then saturation
	always_ff @(posedge clk) begin
		pl_s4     <= advect_gain * $signed({1'b0, flux_in[LW-1:0]});
		ph_s4     <= advect_gain * $signed(flux_in[FW-1:LW]);
		wall_s4   <= wall_in;
		centre_s4 <= centre_in;

		ar_s5     <= prod[GPW:FRAC_BITS];
		wall_s5   <= wall_s4;
		centre_s5 <= centre_s4;

		if (fits) begin
			res_s6.load_value <= acc[DW-1:0];
			res_s6.saturated  <= 1'b0;
		end else begin
			res_s6.load_value <= acc[AW-1] ? tas_pkg::LOAD_MIN : tas_pkg::LOAD_MAX;
			res_s6.saturated  <= 1'b1;
		end
	end

	assign done   = valid_s6;
	assign result = res_s6;

endmodule

>>> sv/temperature_advection_stencil.sv
// Channel   Handshake               Payload
// ------    ---------------------   ------------------------------------
// input     start high, busy low    stencil (tas_pkg::stencil_t)
// result    done, one cycle          result (tas_pkg::result_t)
// config    APB write, pready = 1    pwdata to register at paddr[3:2]
//
// One cell enters per clock; busy stays low, so start may be held every cycle.
// Each result appears on done once its transfer has passed the six register
// stages (operands, stencil products, flux rounding, gain partial products,
// gain rounding, sum and clip).
// Reset clears the configuration registers and the valid bits only; no clearing pass follows.
// The receiver cannot stall, so the pipeline never holds.
`include "temperature_advection_stencil_macros.svh"

module temperature_advection_stencil #(
	parameter int FRAC_BITS = tas_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tas_pkg::stencil_t               stencil,
	output logic                            done,
	output tas_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tas_pkg::PADDR_W-1:0]     paddr,
	input  logic [tas_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tas_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int DW         = tas_pkg::DATA_W;
	localparam int FW         = 2 * (DW + 1) - FRAC_BITS;
	localparam int WRW        = 2 * DW + 1 - FRAC_BITS;
	localparam int PIPE_DEPTH = 6;

	tas_pkg::cfg_t          cfg;
	logic                   accept;
	logic                   valid_s3;
	logic signed [FW-1:0]   flux_s3;
	logic signed [WRW-1:0]  wall_s3;
	logic signed [DW-1:0]   centre_s3;
	logic                   at_limit;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	tas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tas_stencil #(
		.FRAC_BITS (FRAC_BITS)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (accept),
		.stencil   (stencil),
		.cfg       (cfg),
		.valid_s3  (valid_s3),
		.flux_s3   (flux_s3),
		.wall_s3   (wall_s3),
		.centre_s3 (centre_s3)
	);

	tas_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (valid_s3),
		.flux_in     (flux_s3),
		.wall_in     (wall_s3),
		.centre_in   (centre_s3),
		.advect_gain (cfg.advect_gain),
		.done        (done),
		.result      (result)
	);

	// Flag a result that sits at either clip limit
	assign at_limit = (result.load_value == tas_pkg::LOAD_MAX) ||
		(result.load_value == tas_pkg::LOAD_MIN);

	// Every transfer yields exactly one result at the end of the pipeline
	`TAS_ASSERT_DELAY(a_result_follows, accept, PIPE_DEPTH, done, "result missing after transfer")
	`TAS_ASSERT_IMPLY(a_no_spurious, done, $past(accept, PIPE_DEPTH), "result without transfer")
	`TAS_ASSERT_IMPLY(a_clip_value, done && result.saturated, at_limit, "clip not at a limit")

endmodule
